// ===== hw/rtl/mrsb_pkg.sv =====
// shared types, constants and codes of the multithread register scoreboard
// depends on nothing; the other rtl files but the checker refer to it by scoped names
`default_nettype none

package mrsb_pkg;

    localparam int THREADS       = 8;
    localparam int REGS_PER_FILE = 32;
    localparam int ENTRIES       = THREADS * 2 * REGS_PER_FILE;
    localparam int ADDR_W        = $clog2(ENTRIES);
    localparam int REG_W         = $clog2(REGS_PER_FILE);
    localparam int TYPE_W        = 7;
    localparam int ITEM_W        = 42;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TYPE_W-1:0] utype_t;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_MARK  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ENC_R  = 3'd0,
        ENC_R4 = 3'd1,
        ENC_I  = 3'd2,
        ENC_S  = 3'd3,
        ENC_B  = 3'd4,
        ENC_U  = 3'd5,
        ENC_J  = 3'd6
    } enc_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_WRITE,
        ST_RESP
    } state_t;

    // packed in tdata order, last field in the lowest bits
    typedef struct packed {
        logic [4:0] clear_count;
        utype_t     unit_type;
        logic [4:0] rs3;
        logic [4:0] rs2;
        logic [4:0] rs1;
        logic [4:0] rd;
        logic       src_is_float;
        logic       dst_is_float;
        logic [2:0] encoding;
        logic [2:0] thread;
        logic [1:0] operation;
    } item_t;

    typedef struct packed {
        logic   wr;
        logic   rd;
        addr_t  addr;
        utype_t wdata;
    } mem_req_t;

    typedef struct packed {
        logic   valid;
        utype_t hazard_type;
    } resp_t;

    function automatic addr_t table_addr(logic [2:0] thr, logic is_float, logic [4:0] regno);
        return addr_t'({thr, is_float, regno});
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrsb_table.sv =====
// pending-type table: one synchronous single-port memory, read data registered
// depends on mrsb_pkg
`default_nettype none

module mrsb_table (
    input  wire                 aclk,
    input  mrsb_pkg::mem_req_t  req,
    output mrsb_pkg::utype_t    rdata
);

    mrsb_pkg::utype_t mem [mrsb_pkg::ENTRIES];
    mrsb_pkg::utype_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mrsb_seq.sv =====
// sequencer: clearing pass, check walk, mark and clear writes over the table
// depends on mrsb_pkg
`default_nettype none

module mrsb_seq (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  mrsb_pkg::item_t     in_item,
    output mrsb_pkg::mem_req_t  mem_req,
    input  mrsb_pkg::utype_t    mem_rdata,
    output mrsb_pkg::resp_t     resp,
    input  wire                 resp_ready
);

    mrsb_pkg::state_t state_reg, state_next;
    mrsb_pkg::item_t  item_reg;
    mrsb_pkg::addr_t  init_reg, init_next;
    logic [2:0]       idx_reg, idx_next;
    logic [4:0]       run_reg, run_next;
    mrsb_pkg::utype_t hazard_reg, hazard_next;

    logic       thread_ok;
    logic [2:0] chk_count;
    logic       slot_file;
    logic [4:0] slot_reg;

    // number of registers a check walks for an encoding
    function automatic logic [2:0] walk_len(logic [2:0] enc);
        logic [2:0] n;
        unique case (enc)
            mrsb_pkg::ENC_R:  n = 3'd3;
            mrsb_pkg::ENC_R4: n = 3'd4;
            mrsb_pkg::ENC_I,
            mrsb_pkg::ENC_S,
            mrsb_pkg::ENC_B:  n = 3'd2;
            mrsb_pkg::ENC_U,
            mrsb_pkg::ENC_J:  n = 3'd1;
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    // file and register number of one step of the check walk
    always_comb begin
        slot_file = item_reg.dst_is_float;
        slot_reg  = item_reg.rd;
        unique case (item_reg.encoding)
            mrsb_pkg::ENC_S: begin
                if (idx_reg[1:0] == 2'd0) begin
                    slot_reg = item_reg.rs2;
                end else begin
                    slot_file = item_reg.src_is_float;
                    slot_reg  = item_reg.rs1;
                end
            end
            mrsb_pkg::ENC_B: begin
                slot_file = item_reg.src_is_float;
                slot_reg  = (idx_reg[1:0] == 2'd0) ? item_reg.rs1 : item_reg.rs2;
            end
            default: begin
                unique case (idx_reg[1:0])
                    2'd0: slot_reg = item_reg.rd;
                    2'd1: slot_reg = item_reg.rs1;
                    2'd2: slot_reg = item_reg.rs2;
                    2'd3: slot_reg = item_reg.rs3;
                endcase
                if (idx_reg[1:0] != 2'd0) begin
                    slot_file = item_reg.src_is_float;
                end
            end
        endcase
    end

    assign thread_ok = int'(item_reg.thread) < mrsb_pkg::THREADS;
    assign chk_count = walk_len(item_reg.encoding);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrsb_pkg::ST_INIT;
            init_reg  <= '0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
        idx_reg    <= idx_next;
        run_reg    <= run_next;
        hazard_reg <= hazard_next;
    end

    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        idx_next      = idx_reg;
        run_next      = run_reg;
        hazard_next   = hazard_reg;
        in_ready      = 1'b0;
        mem_req       = '0;
        resp.valid    = 1'b0;
        resp.hazard_type = hazard_reg;

        unique case (state_reg)
            mrsb_pkg::ST_INIT: begin
                mem_req.wr   = 1'b1;
                mem_req.addr = init_reg;
                init_next    = init_reg + 1'b1;
                if (init_reg == mrsb_pkg::addr_t'(mrsb_pkg::ENTRIES - 1)) begin
                    state_next = mrsb_pkg::ST_IDLE;
                end
            end

            mrsb_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                // walk starts at step zero in dispatch
                idx_next = '0;
                if (in_valid) begin
                    state_next = mrsb_pkg::ST_DISPATCH;
                end
            end

            mrsb_pkg::ST_DISPATCH: begin
                hazard_next = '0;
                idx_next    = 3'd1;
                run_next    = '0;
                state_next  = mrsb_pkg::ST_RESP;
                if (thread_ok) begin
                    priority case (item_reg.operation)
                        mrsb_pkg::OP_CHECK: begin
                            if (chk_count == 3'd0) begin
                                // nothing to walk: clear integer x0
                                mem_req.wr   = 1'b1;
                                mem_req.addr = mrsb_pkg::table_addr(item_reg.thread, 1'b0, 5'd0);
                            end else begin
                                mem_req.rd   = 1'b1;
                                mem_req.addr = mrsb_pkg::table_addr(item_reg.thread, slot_file,
                                                                    slot_reg);
                                state_next   = mrsb_pkg::ST_READ;
                            end
                        end
                        mrsb_pkg::OP_MARK: begin
                            if (item_reg.encoding != mrsb_pkg::ENC_S &&
                                item_reg.encoding != mrsb_pkg::ENC_B) begin
                                mem_req.wr    = 1'b1;
                                mem_req.addr  = mrsb_pkg::table_addr(item_reg.thread,
                                                    item_reg.dst_is_float, item_reg.rd);
                                mem_req.wdata = item_reg.unit_type;
                            end
                        end
                        mrsb_pkg::OP_CLEAR: begin
                            if (!item_reg.dst_is_float) begin
                                mem_req.wr   = 1'b1;
                                mem_req.addr = mrsb_pkg::table_addr(item_reg.thread, 1'b0,
                                                                    item_reg.rd);
                            end else if (item_reg.clear_count != 5'd0) begin
                                state_next = mrsb_pkg::ST_WRITE;
                            end
                        end
                        default: begin
                            state_next = mrsb_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            mrsb_pkg::ST_READ: begin
                // mem_rdata holds the entry of walk step idx_reg - 1
                if (mem_rdata != '0) begin
                    hazard_next = mem_rdata;
                    state_next  = mrsb_pkg::ST_RESP;
                end else if (idx_reg == chk_count) begin
                    mem_req.wr   = 1'b1;
                    mem_req.addr = mrsb_pkg::table_addr(item_reg.thread, 1'b0, 5'd0);
                    state_next   = mrsb_pkg::ST_RESP;
                end else begin
                    mem_req.rd   = 1'b1;
                    mem_req.addr = mrsb_pkg::table_addr(item_reg.thread, slot_file, slot_reg);
                    idx_next     = idx_reg + 3'd1;
                end
            end

            mrsb_pkg::ST_WRITE: begin
                // float run from rd, register numbers wrap
                mem_req.wr   = 1'b1;
                mem_req.addr = mrsb_pkg::table_addr(item_reg.thread, 1'b1,
                                                    item_reg.rd + run_reg);
                run_next     = run_reg + 5'd1;
                if (run_reg == item_reg.clear_count - 5'd1) begin
                    state_next = mrsb_pkg::ST_RESP;
                end
            end

            mrsb_pkg::ST_RESP: begin
                resp.valid = 1'b1;
                if (resp_ready) begin
                    state_next = mrsb_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mrsb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multithread_register_scoreboard.sv =====
// top level of the multithread register scoreboard: stream ports, output register
// depends on mrsb_pkg, mrsb_table and mrsb_seq
`default_nettype none

// Per-thread pending-write scoreboard for the integer and float register files.
// Each input transaction is a check, a mark or a clear for one hardware thread;
// every transaction returns exactly one result transaction carrying hazard_type
// (the unit type code of the first pending register a check finds, 0 otherwise).
// The table sits in one single-port memory with registered read data and
// takes one access per cycle, so the memory port sets the timing: a check
// reads the registers of its walk in turn, and a float clear of count c
// writes its c entries in turn. One item is worked on at a time; a finished
// result waits in the output register, so the next item is accepted while
// the previous result is still unclaimed. After reset the block sweeps the
// whole table to zero, one entry per cycle (512 entries with eight threads),
// and holds s_tready low until that pass is done.
module multithread_register_scoreboard (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // operation[1:0], thread[4:2], encoding[7:5], dst_is_float[8],
    // src_is_float[9], rd[14:10], rs1[19:15], rs2[24:20], rs3[29:25],
    // unit_type[36:30], clear_count[41:37], zero pad[47:42]
    input  wire [mrsb_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // hazard_type[6:0], zero pad[7]
    output logic [mrsb_pkg::M_TDATA_W-1:0]      m_tdata
);

    mrsb_pkg::item_t    in_item;
    mrsb_pkg::mem_req_t mem_req;
    mrsb_pkg::utype_t   mem_rdata;
    mrsb_pkg::resp_t    resp;
    logic               resp_ready;

    // output register, parts the result side from the sequencer
    logic               out_valid_reg;
    mrsb_pkg::utype_t   out_data_reg;

    assign in_item = mrsb_pkg::item_t'(s_tdata[mrsb_pkg::ITEM_W-1:0]);

    // the result slot is free when empty or being drained this cycle
    assign resp_ready = !out_valid_reg || m_tready;

    mrsb_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .resp       (resp),
        .resp_ready (resp_ready)
    );

    mrsb_table u_table (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (resp.valid && resp_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload loads only when a result moves into the slot
    always_ff @(posedge aclk) begin
        if (resp.valid && resp_ready) begin
            out_data_reg <= resp.hazard_type;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mrsb_pkg::M_TDATA_W'(out_data_reg);

endmodule

`default_nettype wire

// ===== hw/rtl/mrsb_checker.sv =====
// port-level checker for the multithread register scoreboard, bound to the top
// depends on nothing but the top level's ports
`default_nettype none

module mrsb_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [7:0]  m_tdata
);

    // the table clearing pass follows reset, no transaction taken meanwhile
    a_init_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken right after reset");

    // one transaction at a time: no acceptance on the following edge
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back input acceptance");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pad bit above hazard_type stays zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7] == 1'b0)
        else $error("result pad bit set");

endmodule

bind multithread_register_scoreboard mrsb_checker u_mrsb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for multithread_register_scoreboard
// depends on mrsb_pkg and the scoreboard rtl; drives directed then random transactions
// and checks every result against a typed-in value or a behavioral model of the pending table

module tb_top;

    import mrsb_pkg::*;

    // codes the package leaves unnamed but the fields allow
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam logic [2:0] ENC_SPARE  = 3'd7;
    localparam logic       INT_FILE   = 1'b0;
    localparam logic       FLOAT_FILE = 1'b1;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_PCT     = 21;
    localparam int QUIET_LIMIT  = 2000;   // covers the clearing pass after reset
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        item_t  it;
        bit     known;     // expected value typed in below
        utype_t hazard;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // model of the pending table, indexed {thread, file, register}
    utype_t   pending [0:ENTRIES-1];
    // hazard codes still owed by the block, oldest first
    utype_t   hazard_q [$];
    dir_row_t directed [$];
    int       errors;
    int       quiet;
    bit       calm;        // no idling on either side while set

    multithread_register_scoreboard uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int entry(logic [2:0] thr, logic file, logic [4:0] regno);
        return int'({thr, file, regno});
    endfunction

    // applies one transaction to the model table and returns the hazard code it yields
    function automatic utype_t apply_to_table(item_t it);
        logic [4:0] regs [4];
        logic       files [4];
        int         n;
        utype_t     found;
        logic [4:0] r;
        n = 0;
        found = '0;
        if (it.thread < THREADS) begin
            if (it.operation == OP_CHECK) begin
                // walk order per format: destination side first except for branches
                case (it.encoding)
                    ENC_R: begin
                        regs[0] = it.rd;  files[0] = it.dst_is_float;
                        regs[1] = it.rs1; files[1] = it.src_is_float;
                        regs[2] = it.rs2; files[2] = it.src_is_float;
                        n = 3;
                    end
                    ENC_R4: begin
                        regs[0] = it.rd;  files[0] = it.dst_is_float;
                        regs[1] = it.rs1; files[1] = it.src_is_float;
                        regs[2] = it.rs2; files[2] = it.src_is_float;
                        regs[3] = it.rs3; files[3] = it.src_is_float;
                        n = 4;
                    end
                    ENC_I: begin
                        regs[0] = it.rd;  files[0] = it.dst_is_float;
                        regs[1] = it.rs1; files[1] = it.src_is_float;
                        n = 2;
                    end
                    ENC_S: begin
                        // store data register lives in the destination file
                        regs[0] = it.rs2; files[0] = it.dst_is_float;
                        regs[1] = it.rs1; files[1] = it.src_is_float;
                        n = 2;
                    end
                    ENC_B: begin
                        regs[0] = it.rs1; files[0] = it.src_is_float;
                        regs[1] = it.rs2; files[1] = it.src_is_float;
                        n = 2;
                    end
                    ENC_U, ENC_J: begin
                        regs[0] = it.rd;  files[0] = it.dst_is_float;
                        n = 1;
                    end
                    default: n = 0;
                endcase
                for (int i = 0; i < n; i++) begin
                    if (found == '0)
                        found = pending[entry(it.thread, files[i], regs[i])];
                end
                // a clean check also drops anything pending on integer x0
                if (found == '0)
                    pending[entry(it.thread, INT_FILE, 5'd0)] = '0;
            end else if (it.operation == OP_MARK) begin
                if (it.encoding != ENC_S && it.encoding != ENC_B)
                    pending[entry(it.thread, it.dst_is_float, it.rd)] = it.unit_type;
            end else if (it.operation == OP_CLEAR) begin
                if (it.dst_is_float) begin
                    // float return clears a run that wraps past f31
                    for (int i = 0; i < int'(it.clear_count); i++) begin
                        r = it.rd + 5'(i);
                        pending[entry(it.thread, FLOAT_FILE, r)] = '0;
                    end
                end else begin
                    pending[entry(it.thread, INT_FILE, it.rd)] = '0;
                end
            end
        end
        return found;
    endfunction

    task automatic put_row(logic [1:0] op, logic [2:0] thr, logic [2:0] enc, logic df,
                           logic sf, logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
                           logic [4:0] rs3, utype_t ut, logic [4:0] cnt, bit known,
                           utype_t hazard);
        dir_row_t row;
        row.it.operation    = op;
        row.it.thread       = thr;
        row.it.encoding     = enc;
        row.it.dst_is_float = df;
        row.it.src_is_float = sf;
        row.it.rd           = rd;
        row.it.rs1          = rs1;
        row.it.rs2          = rs2;
        row.it.rs3          = rs3;
        row.it.unit_type    = ut;
        row.it.clear_count  = cnt;
        row.known           = known;
        row.hazard          = hazard;
        directed = {directed, row};
    endtask

    // register numbers lean on a few hot entries so checks hit pending marks
    function automatic logic [4:0] pick_reg();
        logic [4:0] hot [5] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd31};
        if ($urandom_range(99) < 60)
            return hot[$urandom_range(4)];
        return 5'($urandom_range(31));
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 44)
            it.operation = OP_CHECK;
        else if (sel < 74)
            it.operation = OP_MARK;
        else if (sel < 94)
            it.operation = OP_CLEAR;
        else
            it.operation = OP_SPARE;
        it.thread       = ($urandom_range(1)) ? 3'($urandom_range(7))
                                              : (($urandom_range(1)) ? 3'd0 : 3'd7);
        it.encoding     = 3'($urandom_range(7));
        it.dst_is_float = 1'($urandom_range(1));
        it.src_is_float = 1'($urandom_range(1));
        it.rd           = pick_reg();
        it.rs1          = pick_reg();
        it.rs2          = pick_reg();
        it.rs3          = pick_reg();
        it.unit_type    = ($urandom_range(99) < 5) ? '0 : utype_t'($urandom_range(127, 1));
        sel = $urandom_range(99);
        if (sel < 80)
            it.clear_count = 5'($urandom_range(16, 1));
        else if (sel < 90)
            it.clear_count = 5'd0;
        else
            it.clear_count = 5'($urandom_range(31, 17));
        return it;
    endfunction

    // presents one transaction, holds it until taken, then records what it owes
    task automatic send(item_t it, bit known, utype_t hazard);
        utype_t want;
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(it);
        do @(posedge aclk); while (!s_tready);
        want = apply_to_table(it);
        hazard_q = {hazard_q, known ? hazard : want};
    endtask

    // result side stalls at random except during the calm stretch
    always @(negedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // result checker
    always @(posedge aclk) begin : check_results
        utype_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (hazard_q.size() == 0) begin
                $display("%0t: unexpected result transaction, hazard_type %0d",
                         $time, m_tdata[TYPE_W-1:0]);
                errors++;
            end else begin
                want = hazard_q.pop_front();
                if (m_tdata[TYPE_W-1:0] !== want) begin
                    $display("%0t: hazard_type mismatch, expected %0d, got %0d",
                             $time, want, m_tdata[TYPE_W-1:0]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        errors   = 0;
        quiet    = 0;
        calm     = 1'b0;
        foreach (pending[i])
            pending[i] = '0;

        //       op         thr   enc        df  sf  rd  rs1 rs2 rs3 unit cnt known hazard
        // table empty after reset
        put_row(OP_CHECK,  3'd0, ENC_R4,    0,  0,  0,  0,  0,  0,  1,   1,  1,  0);
        // widest type code, then found through the destination and a source
        put_row(OP_MARK,   3'd0, ENC_R,     0,  0,  5,  0,  0,  0,  127, 1,  1,  0);
        put_row(OP_CHECK,  3'd0, ENC_R,     0,  0,  5,  31, 31, 31, 1,   1,  1,  127);
        put_row(OP_CHECK,  3'd0, ENC_I,     1,  0,  1,  5,  0,  0,  1,   1,  0,  0);
        // branch and store formats never record a mark
        put_row(OP_MARK,   3'd1, ENC_B,     0,  0,  3,  0,  0,  0,  9,   1,  1,  0);
        put_row(OP_MARK,   3'd1, ENC_S,     0,  0,  3,  0,  0,  0,  9,   1,  1,  0);
        put_row(OP_CHECK,  3'd1, ENC_U,     0,  0,  3,  0,  0,  0,  1,   1,  0,  0);
        // float marks at both ends of the file, last thread
        put_row(OP_MARK,   3'd7, ENC_J,     1,  0,  31, 0,  0,  0,  1,   1,  1,  0);
        put_row(OP_MARK,   3'd7, ENC_U,     1,  0,  0,  0,  0,  0,  2,   1,  1,  0);
        put_row(OP_CHECK,  3'd7, ENC_R4,    0,  1,  0,  1,  2,  31, 1,   1,  0,  0);
        put_row(OP_CHECK,  3'd7, ENC_B,     0,  1,  7,  0,  31, 0,  1,   1,  0,  0);
        put_row(OP_CHECK,  3'd7, ENC_S,     1,  0,  7,  0,  31, 0,  1,   1,  0,  0);
        // float clear running past f31 wraps to f0
        put_row(OP_CLEAR,  3'd7, ENC_R,     1,  0,  31, 0,  0,  0,  1,   2,  1,  0);
        put_row(OP_CHECK,  3'd7, ENC_B,     0,  1,  7,  0,  31, 0,  1,   1,  0,  0);
        // pending x0 reported, then dropped by a clean check with an unused format
        put_row(OP_MARK,   3'd2, ENC_I,     0,  0,  0,  0,  0,  0,  5,   1,  1,  0);
        put_row(OP_CHECK,  3'd2, ENC_J,     0,  0,  0,  0,  0,  0,  1,   1,  0,  0);
        put_row(OP_CHECK,  3'd2, ENC_SPARE, 0,  0,  0,  0,  0,  0,  1,   1,  0,  0);
        // mark with type code zero leaves nothing pending
        put_row(OP_MARK,   3'd3, ENC_R,     0,  0,  4,  0,  0,  0,  0,   1,  1,  0);
        put_row(OP_CHECK,  3'd3, ENC_U,     0,  0,  4,  0,  0,  0,  1,   1,  0,  0);
        // unused operation code, every other field at its top
        put_row(OP_SPARE,  3'd7, ENC_SPARE, 1,  1,  31, 31, 31, 31, 127, 31, 1,  0);
        // zero-length float clear, then the longest run wrapping around
        put_row(OP_MARK,   3'd4, ENC_R,     1,  0,  10, 0,  0,  0,  33,  1,  1,  0);
        put_row(OP_CLEAR,  3'd4, ENC_R,     1,  0,  10, 0,  0,  0,  1,   0,  1,  0);
        put_row(OP_CHECK,  3'd4, ENC_U,     1,  0,  10, 0,  0,  0,  1,   1,  0,  0);
        put_row(OP_CLEAR,  3'd4, ENC_R,     1,  0,  11, 0,  0,  0,  1,   31, 1,  0);
        put_row(OP_CHECK,  3'd4, ENC_U,     1,  0,  10, 0,  0,  0,  1,   1,  0,  0);
        // integer clear ignores the count
        put_row(OP_CLEAR,  3'd0, ENC_R,     0,  0,  5,  0,  0,  0,  1,   16, 1,  0);
        put_row(OP_CHECK,  3'd0, ENC_R,     0,  0,  5,  0,  0,  0,  1,   1,  0,  0);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send(directed[i].it, directed[i].known, directed[i].hazard);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // one long stretch with both sides running flat out
            calm = (i >= 200 && i < 300);
            send(random_item(), 1'b0, '0);
        end
        calm = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (hazard_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
